/* rtl/mte_pkg.sv */
// shared types, constants and functions of the midi track event encoder
package mte_pkg;

  localparam int DELTA_BITS = 28;
  localparam int DUR_W      = 28;
  localparam int VLQ_W      = 28;
  localparam int BYTE_W     = 8;
  localparam int VEL_W      = 7;
  localparam int GRP_W      = 2;

  localparam logic [DELTA_BITS-1:0] DELTA_MAX   = '1;
  localparam logic [DELTA_BITS-1:0] DELAY_RESET = DELTA_BITS'(1);

  localparam logic [VEL_W-1:0] VEL_RESET = 7'd127;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_NOTE = 2'd0;
  localparam logic [1:0] OP_REST = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  localparam logic [BYTE_W-1:0] NOTE_ON_BYTE   = 8'h90;
  localparam logic [BYTE_W-1:0] NOTE_OFF_BYTE  = 8'h80;
  localparam logic [BYTE_W-1:0] END_DELTA_BYTE = 8'h01;
  localparam logic [BYTE_W-1:0] META_BYTE      = 8'hff;
  localparam logic [BYTE_W-1:0] END_TRACK_BYTE = 8'h2f;
  localparam logic [BYTE_W-1:0] END_LEN_BYTE   = 8'h00;

  localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'd32;
  localparam logic [BYTE_W-1:0] CHAR_B       = 8'h42;
  localparam logic [BYTE_W-1:0] CHAR_C       = 8'h43;
  localparam logic [BYTE_W-1:0] CHAR_SHARP   = 8'h23;
  localparam logic [BYTE_W-1:0] CHAR_FLAT    = 8'h62;

  typedef struct packed {
    logic                  is_end;
    logic [BYTE_W-1:0]     note;
    logic [DELTA_BITS-1:0] delay;
    logic [GRP_W-1:0]      delay_grps;
    logic [DELTA_BITS-1:0] dur;
    logic [GRP_W-1:0]      dur_grps;
  } cmd_t;

  function automatic logic [BYTE_W-1:0] note_number(
    logic [BYTE_W-1:0] key,
    logic [BYTE_W-1:0] acc,
    logic [3:0]        oct
  );
    logic [BYTE_W-1:0] k;
    logic [BYTE_W-1:0] oct12;
    k = key;
    if (k >= CHAR_LOWER_A && k <= CHAR_LOWER_Z) begin
      k = k - CASE_OFFSET;
    end
    if ($signed(k) <= $signed(CHAR_B)) begin
      k = k + 8'd7;
    end
    k = (k - CHAR_C) << 1;
    if ($signed(k) > $signed(8'd5)) begin
      k = k - 8'd1;
    end
    oct12 = {1'b0, oct, 3'b000} + {2'b00, oct, 2'b00};
    k = k + oct12;
    if (acc == CHAR_SHARP) begin
      k = k + 8'd1;
    end else if (acc == CHAR_FLAT) begin
      k = k - 8'd1;
    end
    return k;
  endfunction

  // index of the most significant 7-bit group
  function automatic logic [GRP_W-1:0] vlq_top_group(logic [DELTA_BITS-1:0] v);
    logic [VLQ_W-1:0] w;
    w = VLQ_W'(v);
    if (w[VLQ_W-1:21] != '0) begin
      return 2'd3;
    end else if (w[VLQ_W-1:14] != '0) begin
      return 2'd2;
    end else if (w[VLQ_W-1:7] != '0) begin
      return 2'd1;
    end
    return 2'd0;
  endfunction

  function automatic logic [BYTE_W-1:0] vlq_byte(
    logic [DELTA_BITS-1:0] v,
    logic [GRP_W-1:0]      g
  );
    logic [VLQ_W-1:0] w;
    logic [6:0]       grp7;
    w = VLQ_W'(v);
    unique case (g)
      2'd0:    grp7 = w[6:0];
      2'd1:    grp7 = w[13:7];
      2'd2:    grp7 = w[20:14];
      default: grp7 = w[27:21];
    endcase
    return {(g != 2'd0), grp7};
  endfunction

endpackage

/* rtl/mte_front.sv */
// front end: takes requests, folds rests into the pending delay, builds commands
module mte_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        opcode,
  input  logic [7:0]                        key_char,
  input  logic [7:0]                        accidental_char,
  input  logic [3:0]                        octave,
  input  logic [27:0]                       duration,
  output logic                              push_valid,
  output mte_pkg::cmd_t                     push_cmd,
  input  logic                              push_ready
);
  import mte_pkg::*;

  logic [DELTA_BITS-1:0] pending_delay;
  logic [DELTA_BITS-1:0] pending_delay_next;
  logic [DELTA_BITS-1:0] dur_sat;
  logic [DELTA_BITS:0]   rest_sum;
  logic                  accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (duration > DUR_W'(DELTA_MAX)) begin
      dur_sat = DELTA_MAX;
    end else begin
      dur_sat = duration[DELTA_BITS-1:0];
    end
  end

  assign rest_sum = {1'b0, pending_delay} + {1'b0, dur_sat};

  always_comb begin
    push_cmd.is_end     = (opcode == OP_END);
    push_cmd.note       = note_number(key_char, accidental_char, octave);
    push_cmd.delay      = pending_delay;
    push_cmd.delay_grps = vlq_top_group(pending_delay);
    push_cmd.dur        = dur_sat;
    push_cmd.dur_grps   = vlq_top_group(dur_sat);
  end

  assign push_valid = accept && (opcode == OP_NOTE || opcode == OP_END);

  always_comb begin
    pending_delay_next = pending_delay;
    if (accept) begin
      case (opcode)
        OP_NOTE: pending_delay_next = '0;
        OP_REST: begin
          if (rest_sum > {1'b0, DELTA_MAX}) begin
            pending_delay_next = DELTA_MAX;
          end else begin
            pending_delay_next = rest_sum[DELTA_BITS-1:0];
          end
        end
        OP_END:  pending_delay_next = DELAY_RESET;
        default: pending_delay_next = pending_delay;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_delay <= DELAY_RESET;
    end else begin
      pending_delay <= pending_delay_next;
    end
  end

  a_note_clears_delay: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_NOTE) |=> (pending_delay == '0))
    else $error("pending delay not cleared after note");

  a_rest_never_shrinks: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_REST) |=> (pending_delay >= $past(pending_delay)))
    else $error("rest reduced the pending delay");

endmodule

/* rtl/mte_queue.sv */
// short command queue between front end and serializer
module mte_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  mte_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output mte_pkg::cmd_t pop_cmd,
  input  logic          pop_ready
);
  import mte_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

/* rtl/mte_back.sv */
// back end: serializes one command into track event bytes, holds the velocity register
module mte_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  input  mte_pkg::cmd_t pop_cmd,
  output logic          pop_ready,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [6:0]    cfg_velocity,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          last_byte
);
  import mte_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_DELAY   = 10'b0000000010,
    S_ON      = 10'b0000000100,
    S_KEY_ON  = 10'b0000001000,
    S_VEL_ON  = 10'b0000010000,
    S_DUR     = 10'b0000100000,
    S_OFF     = 10'b0001000000,
    S_KEY_OFF = 10'b0010000000,
    S_VEL_OFF = 10'b0100000000,
    S_END     = 10'b1000000000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [GRP_W-1:0]  grp;
  logic [GRP_W-1:0]  grp_next;
  cmd_t              cur;
  logic [VEL_W-1:0]  velocity;
  logic              advance;
  logic              emit;
  logic [BYTE_W-1:0] byte_val;
  logic              last_val;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    grp_next   = grp;
    emit       = 1'b0;
    byte_val   = '0;
    last_val   = 1'b0;
    pop_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_next = pop_cmd.is_end ? S_END : S_DELAY;
          grp_next   = pop_cmd.is_end ? 2'd3 : pop_cmd.delay_grps;
        end
      end
      S_DELAY: begin
        emit     = advance;
        byte_val = vlq_byte(cur.delay, grp);
        if (advance) begin
          if (grp == 2'd0) begin
            state_next = S_ON;
          end else begin
            grp_next = grp - 2'd1;
          end
        end
      end
      S_ON: begin
        emit     = advance;
        byte_val = NOTE_ON_BYTE;
        if (advance) begin
          state_next = S_KEY_ON;
        end
      end
      S_KEY_ON: begin
        emit     = advance;
        byte_val = cur.note;
        if (advance) begin
          state_next = S_VEL_ON;
        end
      end
      S_VEL_ON: begin
        emit     = advance;
        byte_val = {1'b0, velocity};
        if (advance) begin
          state_next = S_DUR;
          grp_next   = cur.dur_grps;
        end
      end
      S_DUR: begin
        emit     = advance;
        byte_val = vlq_byte(cur.dur, grp);
        if (advance) begin
          if (grp == 2'd0) begin
            state_next = S_OFF;
          end else begin
            grp_next = grp - 2'd1;
          end
        end
      end
      S_OFF: begin
        emit     = advance;
        byte_val = NOTE_OFF_BYTE;
        if (advance) begin
          state_next = S_KEY_OFF;
        end
      end
      S_KEY_OFF: begin
        emit     = advance;
        byte_val = cur.note;
        if (advance) begin
          state_next = S_VEL_OFF;
        end
      end
      S_VEL_OFF: begin
        emit     = advance;
        byte_val = {1'b0, velocity};
        last_val = 1'b1;
        if (advance) begin
          state_next = S_IDLE;
        end
      end
      S_END: begin
        emit = advance;
        unique case (grp)
          2'd3:    byte_val = END_DELTA_BYTE;
          2'd2:    byte_val = META_BYTE;
          2'd1:    byte_val = END_TRACK_BYTE;
          default: byte_val = END_LEN_BYTE;
        endcase
        last_val = (grp == 2'd0);
        if (advance) begin
          if (grp == 2'd0) begin
            state_next = S_IDLE;
          end else begin
            grp_next = grp - 2'd1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      grp       <= '0;
      out_valid <= 1'b0;
      velocity  <= VEL_RESET;
    end else begin
      state <= state_next;
      grp   <= grp_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        velocity <= cfg_velocity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && pop_valid) begin
      cur <= pop_cmd;
    end
    if (emit) begin
      out_byte  <= byte_val;
      last_byte <= last_val;
    end
  end

  a_vlq_cont_bit: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DELAY || state == S_DUR) && advance && grp != 2'd0) |=> out_byte[7])
    else $error("vlq continuation bit missing");

  a_pop_starts_item: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready) |=> (state == S_DELAY || state == S_END))
    else $error("popped command did not start a sequence");

  a_velocity_byte: assert property (@(posedge clk) disable iff (rst)
    ((state == S_VEL_ON || state == S_VEL_OFF) && advance) |=>
      (out_byte == {1'b0, $past(velocity)}))
    else $error("velocity byte mismatch");

endmodule

/* rtl/midi_track_event_encoder_top.sv */
// top level of the midi track event encoder: front end, command queue, byte serializer
//
//   channel | direction | handshake             | payload
//   in      | in        | in_valid / in_ready   | opcode key_char accidental_char octave duration
//   out     | out       | out_valid / out_ready | out_byte last_byte
//   cfg     | in        | cfg_valid / cfg_ready | cfg_velocity
//
// a rest is folded into the pending delay in the front end and produces no bytes
// a note is loaded in the serializer's idle state, then sent as 8..14 bytes, one byte per cycle while out_ready allows
// an end of track is loaded the same way and sent as 4 bytes; the serializer sets the item rate
// a two-entry command queue lets the front end keep taking requests while bytes drain
// synchronous active-high reset; pending delay resets to 1, velocity to 127
// out_ready low holds the byte register, then the queue fills and in_ready drops
module midi_track_event_encoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  key_char,
  input  logic [7:0]  accidental_char,
  input  logic [3:0]  octave,
  input  logic [27:0] duration,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_velocity
);
  import mte_pkg::*;

  logic push_valid;
  cmd_t push_cmd;
  logic push_ready;
  logic pop_valid;
  cmd_t pop_cmd;
  logic pop_ready;

  mte_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .key_char        (key_char),
    .accidental_char (accidental_char),
    .octave          (octave),
    .duration        (duration),
    .push_valid      (push_valid),
    .push_cmd        (push_cmd),
    .push_ready      (push_ready)
  );

  mte_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  mte_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_cmd      (pop_cmd),
    .pop_ready    (pop_ready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_velocity (cfg_velocity),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_byte    (last_byte)
  );

endmodule

/* sim/tb_top.sv */
// self-checking testbench for the midi track event encoder: byte stream prediction and checks
`timescale 1ns / 100ps

module tb_top;
  import mte_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SEMITONES      = 12;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 400;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  key;
    logic [7:0]  acc;
    logic [3:0]  oct;
    logic [27:0] dur;
  } track_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } track_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = OP_NOTE;
  logic [7:0]  key_char = '0;
  logic [7:0]  accidental_char = '0;
  logic [3:0]  octave = '0;
  logic [27:0] duration = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_velocity = VEL_RESET;

  track_item_t pending_items[$];
  logic [6:0]  velocity_writes[$];
  track_byte_t item_bytes[$];
  track_byte_t expected_bytes[$];

  logic [DELTA_BITS-1:0] delta_acc = DELAY_RESET;
  logic [VEL_W-1:0]      velocity_now = VEL_RESET;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int bytes_checked = 0;
  int notes_seen = 0;
  int rests_seen = 0;
  int ends_seen = 0;
  int ignored_seen = 0;
  int settings_used = 0;

  midi_track_event_encoder_top uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .key_char        (key_char),
    .accidental_char (accidental_char),
    .octave          (octave),
    .duration        (duration),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .last_byte       (last_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_velocity    (cfg_velocity)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] pitch_of(logic [7:0] key, logic [7:0] acc, logic [3:0] oct);
    logic [7:0] k;
    k = key;
    if (k >= CHAR_LOWER_A && k <= CHAR_LOWER_Z) begin
      k = k - CASE_OFFSET;
    end
    if ($signed(k) <= $signed(CHAR_B)) begin
      k = k + 8'd7;
    end
    k = 8'((k - CHAR_C) * 2);
    if ($signed(k) > 8'sd5) begin
      k = k - 8'd1;
    end
    k = k + 8'(oct * SEMITONES);
    if (acc == CHAR_SHARP) begin
      k = k + 8'd1;
    end else if (acc == CHAR_FLAT) begin
      k = k - 8'd1;
    end
    return k;
  endfunction

  task automatic emit_byte(input logic [7:0] b);
    item_bytes.push_back({b, 1'b0});
  endtask

  task automatic emit_vlq(input logic [27:0] v);
    int groups;
    int g;
    groups = 1;
    while (groups < 4 && (v >> (7 * groups)) != 0) begin
      groups++;
    end
    for (g = groups - 1; g >= 0; g--) begin
      emit_byte({g > 0, v[7*g +: 7]});
    end
  endtask

  // expected bytes of one accepted request, appended to the expected stream
  task automatic encode_item(input logic [1:0] op, input logic [7:0] key,
                             input logic [7:0] acc, input logic [3:0] oct,
                             input logic [27:0] dur);
    logic [7:0]  pitch;
    logic [28:0] sum;
    item_bytes.delete();
    pitch = pitch_of(key, acc, oct);
    case (op)
      OP_NOTE: begin
        emit_vlq(delta_acc);
        emit_byte(NOTE_ON_BYTE);
        emit_byte(pitch);
        emit_byte({1'b0, velocity_now});
        emit_vlq(dur);
        emit_byte(NOTE_OFF_BYTE);
        emit_byte(pitch);
        emit_byte({1'b0, velocity_now});
        delta_acc = '0;
        notes_seen++;
      end
      OP_REST: begin
        sum = {1'b0, delta_acc} + {1'b0, dur};
        delta_acc = (sum > {1'b0, DELTA_MAX}) ? DELTA_MAX : sum[27:0];
        rests_seen++;
      end
      OP_END: begin
        emit_byte(END_DELTA_BYTE);
        emit_byte(META_BYTE);
        emit_byte(END_TRACK_BYTE);
        emit_byte(END_LEN_BYTE);
        delta_acc = DELAY_RESET;
        ends_seen++;
      end
      default: begin
        ignored_seen++;
      end
    endcase
    if (item_bytes.size() != 0) begin
      item_bytes[item_bytes.size() - 1].last = 1'b1;
    end
    foreach (item_bytes[i]) begin
      expected_bytes.push_back(item_bytes[i]);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    track_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        encode_item(opcode, key_char, accidental_char, octave, duration);
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_items.pop_front();
          opcode          <= it.op;
          key_char        <= it.key;
          accidental_char <= it.acc;
          octave          <= it.oct;
          duration        <= it.dur;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // velocity register writes
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        velocity_now = cfg_velocity;
        settings_used++;
      end
      if (!cfg_valid || cfg_ready) begin
        if (velocity_writes.size() != 0) begin
          cfg_velocity <= velocity_writes.pop_front();
          cfg_valid    <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure, with an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_request != 0) begin
        hold_cnt = hold_request;
        hold_request = 0;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // byte checker
  always @(posedge clk) begin
    track_byte_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte %02h (last %0b)", out_byte, last_byte);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (out_byte !== want.data) begin
          $error("out_byte: expected %02h, actual %02h", want.data, out_byte);
          mismatches++;
        end
        if (last_byte !== want.last) begin
          $error("last_byte: expected %0b, actual %0b", want.last, last_byte);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d bytes still expected",
                 WATCHDOG_LIMIT, expected_bytes.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic add_item(input logic [1:0] op, input logic [7:0] key, input logic [7:0] acc,
                          input logic [3:0] oct, input logic [27:0] dur);
    pending_items.push_back({op, key, acc, oct, dur});
  endtask

  function automatic logic [27:0] random_duration();
    case ($urandom_range(6))
      0: return 28'($urandom_range(127));
      1: return 28'($urandom_range(16383));
      2: return 28'($urandom_range(2097151));
      3: return 28'($urandom);
      4: return 28'($urandom_range(4));
      default: begin
        case ($urandom_range(7))
          0: return 28'd0;
          1: return 28'd127;
          2: return 28'd128;
          3: return 28'd16383;
          4: return 28'd16384;
          5: return 28'd2097151;
          6: return 28'd2097152;
          default: return DELTA_MAX;
        endcase
      end
    endcase
  endfunction

  task automatic add_random_item();
    int r;
    logic [1:0] op;
    logic [7:0] key;
    logic [7:0] acc;
    logic [3:0] oct;
    r = $urandom_range(99);
    op = (r < 55) ? OP_NOTE : (r < 80) ? OP_REST : (r < 95) ? OP_END : OP_UNUSED;
    if ($urandom_range(99) < 65) begin
      key = "A" + 8'($urandom_range(6));
      if ($urandom_range(1) == 1) begin
        key = key + CASE_OFFSET;
      end
    end else begin
      key = 8'($urandom_range(255));
    end
    case ($urandom_range(3))
      0: acc = CHAR_SHARP;
      1: acc = CHAR_FLAT;
      default: acc = 8'($urandom_range(255));
    endcase
    oct = ($urandom_range(99) < 80) ? 4'($urandom_range(10)) : 4'($urandom_range(15));
    add_item(op, key, acc, oct, random_duration());
  endtask

  // wait for the block to go quiet, then let it drain a little further
  task automatic settle();
    do begin
      @(negedge clk);
    end while (pending_items.size() != 0 || in_valid || expected_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [6:0] vel, input int idle_pct, input int stall_pct,
                           input int n_items, input int hold);
    velocity_writes.push_back(vel);
    do begin
      @(negedge clk);
    end while (velocity_writes.size() != 0 || cfg_valid);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) add_random_item();
    if (hold != 0) begin
      hold_request = hold;
    end
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_item(OP_NOTE, "C", 8'h20, 4'd5, 28'd0);
    add_item(OP_NOTE, "a", CHAR_SHARP, 4'd0, 28'd127);
    add_item(OP_NOTE, "G", CHAR_FLAT, 4'd10, 28'd128);
    add_item(OP_NOTE, "g", 8'h00, 4'd15, 28'd16383);
    add_item(OP_NOTE, 8'h00, 8'hff, 4'd0, 28'd16384);
    add_item(OP_NOTE, 8'hff, CHAR_SHARP, 4'd10, 28'd2097151);
    add_item(OP_NOTE, 8'h80, CHAR_FLAT, 4'd3, 28'd2097152);
    add_item(OP_NOTE, 8'h7f, 8'h42, 4'd4, DELTA_MAX);
    add_item(OP_NOTE, "B", CHAR_FLAT, 4'd0, 28'd1);
    add_item(OP_NOTE, "z", "B", 4'd7, 28'd300);
    add_item(OP_REST, 8'hff, 8'hff, 4'd15, DELTA_MAX);
    add_item(OP_REST, "C", CHAR_SHARP, 4'd2, 28'd5);
    add_item(OP_NOTE, "D", CHAR_SHARP, 4'd4, 28'd96);
    add_item(OP_REST, "E", 8'h00, 4'd0, 28'd0);
    add_item(OP_NOTE, "e", CHAR_FLAT, 4'd6, 28'd48);
    add_item(OP_REST, 8'h00, 8'h00, 4'd9, 28'd200);
    add_item(OP_END, "F", CHAR_SHARP, 4'd15, DELTA_MAX);
    add_item(OP_NOTE, "F", CHAR_SHARP, 4'd5, 28'd24);
    add_item(OP_UNUSED, "A", CHAR_SHARP, 4'd15, DELTA_MAX);
    add_item(OP_REST, "A", 8'h00, 4'd0, 28'd16384);
    add_item(OP_NOTE, "A", 8'h00, 4'd4, 28'd1000);
    add_item(OP_END, 8'h00, 8'h00, 4'd0, 28'd0);
    add_item(OP_END, 8'hff, 8'hff, 4'd15, 28'd1);
    settle();

    run_phase(7'd0, 0, 0, 105, 0);
    run_phase(7'd127, 64, 0, 105, 0);
    run_phase(7'($urandom_range(127)), 0, 64, 105, 0);
    run_phase(7'd1, 36, 36, 105, 0);
    run_phase(7'($urandom_range(127)), 0, 0, 30, LONG_HOLD);

    $display("covered %0d notes, %0d rests, %0d end-of-track and %0d ignored requests",
             notes_seen, rests_seen, ends_seen, ignored_seen);
    $display("checked %0d bytes over %0d velocity writes, %0d mismatches",
             bytes_checked, settings_used, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/mte_pkg.sv
rtl/mte_front.sv
rtl/mte_queue.sv
rtl/mte_back.sv
rtl/midi_track_event_encoder_top.sv
sim/tb_top.sv
